[src/mks_pkg.sv]
`default_nettype none
package mks_pkg;

  // Scan phases
  localparam logic [1:0] PH_SCAN     = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_HOLD     = 2'd2;

  localparam logic [3:0] ROWS_IDLE   = 4'h0f;
  localparam logic [1:0] LAST_COLUMN = 2'd3;
  localparam logic [7:0] DEBOUNCE_RESET = 8'd10;

  // Result of decoding a row pattern with exactly one row low
  typedef struct packed {
    logic       hit;
    logic [1:0] row;
  } row_hit_t;

  function automatic row_hit_t single_row(input logic [3:0] rows);
    row_hit_t res;
    res = '{hit: 1'b0, row: 2'd0};
    case (rows)
      4'h07: res = '{hit: 1'b1, row: 2'd0};
      4'h0b: res = '{hit: 1'b1, row: 2'd1};
      4'h0d: res = '{hit: 1'b1, row: 2'd2};
      4'h0e: res = '{hit: 1'b1, row: 2'd3};
      default: res = '{hit: 1'b0, row: 2'd0};
    endcase
    return res;
  endfunction

  // ASCII legend of a key number, 0 for none
  function automatic logic [6:0] key_legend(input logic [4:0] key);
    logic [6:0] ch;
    case (key)
      5'd1:  ch = 7'h31; // '1'
      5'd2:  ch = 7'h34; // '4'
      5'd3:  ch = 7'h37; // '7'
      5'd4:  ch = 7'h2a; // '*'
      5'd5:  ch = 7'h32; // '2'
      5'd6:  ch = 7'h35; // '5'
      5'd7:  ch = 7'h38; // '8'
      5'd8:  ch = 7'h30; // '0'
      5'd9:  ch = 7'h33; // '3'
      5'd10: ch = 7'h36; // '6'
      5'd11: ch = 7'h39; // '9'
      5'd12: ch = 7'h23; // '#'
      5'd13: ch = 7'h41; // 'A'
      5'd14: ch = 7'h42; // 'B'
      5'd15: ch = 7'h43; // 'C'
      5'd16: ch = 7'h44; // 'D'
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

[src/matrix_keypad_scanner_top.sv]
// A result is loaded into the output register in the cycle after its request is accepted.
// One request per cycle while in_stall is low; the column state updates once per accepted tick.
// A request is taken while a finished result waits if that result leaves in the same cycle.
// Reset (rst_n low, synchronous): column 0, scanning phase, no sweep key,
// debounce_ticks back to 10, output register empty.
`default_nettype none
module matrix_keypad_scanner_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] in_row_levels,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_column_drive,
  output logic            out_sweep_done,
  output logic [4:0]      out_key_number,
  output logic [6:0]      out_key_char
);
  import mks_pkg::*;

  logic [7:0] debounce_ticks_r;
  logic [1:0] column_index_r, column_index_nxt;
  logic [1:0] scan_phase_r, scan_phase_nxt;
  logic [7:0] debounce_count_r, debounce_count_nxt;
  logic [4:0] sweep_key_r, sweep_key_nxt;
  logic       out_valid_r;
  logic [3:0] column_drive_r, column_drive_nxt;
  logic       sweep_done_r, sweep_done_nxt;
  logic [4:0] key_number_r, key_number_nxt;
  logic [6:0] key_char_r;
  logic       accept;
  logic       advance;
  row_hit_t   hit;
  logic [4:0] held_key_m1;

  // Take a request when the output register is empty or drains this cycle
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign hit         = single_row(in_row_levels);
  assign held_key_m1 = sweep_key_r - 5'd1;

  // Decide the phase transition for this tick
  always_comb begin
    scan_phase_nxt     = scan_phase_r;
    debounce_count_nxt = debounce_count_r;
    sweep_key_nxt      = sweep_key_r;
    advance            = 1'b0;
    case (scan_phase_r)
      PH_DEBOUNCE: begin
        if (debounce_count_r != 8'd0) begin
          debounce_count_nxt = debounce_count_r - 8'd1;
        end else if (hit.hit) begin
          sweep_key_nxt  = {1'b0, column_index_r, hit.row} + 5'd1;
          scan_phase_nxt = PH_HOLD;
        end else begin
          advance = 1'b1;
        end
      end
      PH_HOLD: begin
        if (sweep_key_r == 5'd0 || !hit.hit || hit.row != held_key_m1[1:0]) begin
          advance = 1'b1;
        end
      end
      default: begin
        if (in_row_levels != ROWS_IDLE) begin
          scan_phase_nxt     = PH_DEBOUNCE;
          debounce_count_nxt = debounce_ticks_r;
        end else begin
          advance = 1'b1;
        end
      end
    endcase

    // Move to the next column, closing the sweep after the last one
    column_index_nxt = column_index_r;
    sweep_done_nxt   = 1'b0;
    key_number_nxt   = 5'd0;
    if (advance) begin
      scan_phase_nxt     = PH_SCAN;
      debounce_count_nxt = 8'd0;
      if (column_index_r == LAST_COLUMN) begin
        sweep_done_nxt   = 1'b1;
        key_number_nxt   = (sweep_key_r > 5'd16) ? 5'd0 : sweep_key_r;
        sweep_key_nxt    = 5'd0;
        column_index_nxt = 2'd0;
      end else begin
        column_index_nxt = column_index_r + 2'd1;
      end
    end
    column_drive_nxt = ~(4'b0001 << column_index_nxt);
  end

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      debounce_ticks_r <= cfg_wr_data;
    end
  end

  // Advance scan state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_index_r   <= 2'd0;
      scan_phase_r     <= PH_SCAN;
      debounce_count_r <= 8'd0;
      sweep_key_r      <= 5'd0;
    end else if (accept) begin
      column_index_r   <= column_index_nxt;
      scan_phase_r     <= scan_phase_nxt;
      debounce_count_r <= debounce_count_nxt;
      sweep_key_r      <= sweep_key_nxt;
    end
  end

  // Output register: fill on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      column_drive_r <= column_drive_nxt;
      sweep_done_r   <= sweep_done_nxt;
      key_number_r   <= key_number_nxt;
      key_char_r     <= key_legend(key_number_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column_drive = column_drive_r;
  assign out_sweep_done   = sweep_done_r;
  assign out_key_number   = key_number_r;
  assign out_key_char     = key_char_r;

endmodule
`default_nettype wire

[src/mks_checker.sv]
`default_nettype none
module mks_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       cfg_wr_en,
  input wire logic [7:0] cfg_wr_data,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [3:0] in_row_levels,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] out_column_drive,
  input wire logic       out_sweep_done,
  input wire logic [4:0] out_key_number,
  input wire logic [6:0] out_key_char
);
  import mks_pkg::*;

  // Exactly one column driven low in every result
  a_one_cold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(~out_column_drive))
    else $error("column drive is not one-cold");

  // Key fields are zero outside the end of a sweep
  a_key_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sweep_done) |-> (out_key_number == 5'd0 && out_key_char == 7'd0))
    else $error("key reported outside sweep end");

  // Legend follows the key number
  a_legend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_number <= 5'd16 && out_key_char == key_legend(out_key_number)))
    else $error("key legend mismatch");

  // A new request is never refused while the output side is free
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // A stalled result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind matrix_keypad_scanner_top mks_checker u_mks_checker (.*);
`default_nettype wire
